// ===== rtl/rlpv_pkg.sv =====
// Shared types and constants for the resonant lowpass and decay amplifier block.
// Holds coefficient/length widths, configuration register indexes and the config struct.
// No dependencies.
package rlpv_pkg;

  localparam int COEF_BITS    = 16;
  localparam int COEF_FRAC    = 8;
  localparam int LEN_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_B1   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FB_A1     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FB_A2     = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_LEN = 2'd3;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] gain_b1;
    logic signed [COEF_BITS-1:0] fb_a1;
    logic signed [COEF_BITS-1:0] fb_a2;
    logic [LEN_BITS-1:0]         decay_length;
  } cfg_t;

endpackage

// ===== rtl/rlpv_front.sv =====
// Front end: two-entry request queue that accepts input samples with their gate bit.
// Decouples the push side from the arithmetic back end.
// Depends on nothing but the top level's DATA_BITS parameter.
module rlpv_front #(
  parameter int DATA_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic signed [DATA_BITS-1:0] sample_in_i,
  input  logic                        gate_i,
  output logic                        item_valid_o,
  output logic signed [DATA_BITS-1:0] item_sample_o,
  output logic                        item_gate_o,
  input  logic                        item_take_i
);

  logic [DATA_BITS:0] mem_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               wr_en, rd_en;

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign wr_en        = push_i && !full_o;
  assign rd_en        = item_take_i && item_valid_o;

  assign item_sample_o = mem_q[rd_ptr_q][DATA_BITS:1];
  assign item_gate_o   = mem_q[rd_ptr_q][0];

  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= {sample_in_i, gate_i};
    end
  end

endmodule

// ===== rtl/rlpv_back.sv =====
// Back end: two-pole filter on one shared multiplier, saturation, decay envelope
// with a restoring divider, and the result register. Uses rlpv_pkg.
// The sequencer handles one request at a time.
module rlpv_back #(
  parameter int DATA_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rlpv_pkg::cfg_t              cfg_i,
  input  logic                        item_valid_i,
  input  logic signed [DATA_BITS-1:0] item_sample_i,
  input  logic                        item_gate_i,
  output logic                        item_take_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic signed [DATA_BITS-1:0] sample_out_o
);

  localparam int PROD_BITS  = rlpv_pkg::COEF_BITS + DATA_BITS;
  localparam int ACC_BITS   = PROD_BITS + 2;
  localparam int LEN_BITS   = rlpv_pkg::LEN_BITS;
  localparam int NPROD_BITS = DATA_BITS + LEN_BITS;
  localparam int QBITS      = DATA_BITS - 1;
  localparam int STEP_BITS  = $clog2(DATA_BITS);

  localparam logic signed [ACC_BITS-1:0] Y_HI =
    (ACC_BITS'(1) <<< (DATA_BITS - 1)) - ACC_BITS'(1);
  localparam logic signed [ACC_BITS-1:0] Y_LO = -Y_HI - ACC_BITS'(1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_SAT   = 3'd3;
  localparam logic [2:0] ST_VMUL  = 3'd4;
  localparam logic [2:0] ST_DLOAD = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0]                   state_q, state_d;
  logic [STEP_BITS-1:0]         step_q, step_d;
  logic signed [DATA_BITS-1:0]  x_q;
  logic                         gate_q;
  logic signed [DATA_BITS-1:0]  y1_q, y2_q, y_q;
  logic signed [PROD_BITS-1:0]  prod_q;
  logic signed [ACC_BITS-1:0]   acc_q;
  logic [LEN_BITS-1:0]          count_q, count_d;
  logic                         neg_q;
  logic [DATA_BITS-1:0]         mag_q;
  logic [LEN_BITS-1:0]          diff_q;
  logic [NPROD_BITS-1:0]        nprod_q;
  logic [LEN_BITS-1:0]          rem_q;
  logic [QBITS-1:0]             low_q;
  logic                         out_valid_q, out_valid_d;
  logic signed [DATA_BITS-1:0]  out_q;

  logic signed [rlpv_pkg::COEF_BITS-1:0] mul_coef;
  logic signed [DATA_BITS-1:0]           mul_opnd;
  logic signed [PROD_BITS-1:0]           mul_res;
  logic signed [ACC_BITS-1:0]            acc_shr;
  logic signed [DATA_BITS-1:0]           y_sat;
  logic [LEN_BITS-1:0]                   len_eff, cnt_clip;
  logic [LEN_BITS:0]                     div_shift, div_sub;
  logic                                  div_ge;
  logic [DATA_BITS-1:0]                  quot;
  logic signed [DATA_BITS-1:0]           res;
  logic                                  out_free;

  // Shared multiplier: one filter term per cycle.
  always_comb begin
    case (step_q[1:0])
      2'd0: begin
        mul_coef = cfg_i.gain_b1;
        mul_opnd = x_q;
      end
      2'd1: begin
        mul_coef = cfg_i.fb_a1;
        mul_opnd = y1_q;
      end
      default: begin
        mul_coef = cfg_i.fb_a2;
        mul_opnd = y2_q;
      end
    endcase
  end
  assign mul_res = mul_coef * mul_opnd;

  assign acc_shr = acc_q >>> rlpv_pkg::COEF_FRAC;
  assign y_sat   = (acc_shr > Y_HI) ? Y_HI[DATA_BITS-1:0] :
                   (acc_shr < Y_LO) ? Y_LO[DATA_BITS-1:0] : acc_shr[DATA_BITS-1:0];

  // A zero length behaves as one; a count above the length reads as the length.
  assign len_eff  = (cfg_i.decay_length == '0) ? LEN_BITS'(1) : cfg_i.decay_length;
  assign cnt_clip = (count_q < len_eff) ? count_q : len_eff;

  assign div_shift = {rem_q, low_q[QBITS-1]};
  assign div_sub   = div_shift - {1'b0, len_eff};
  assign div_ge    = (div_shift >= {1'b0, len_eff});

  assign quot     = {1'b0, low_q};
  assign res      = gate_q ? y_q : (neg_q ? -$signed(quot) : $signed(quot));
  assign out_free = !out_valid_q || pop_i;

  assign item_take_o  = (state_q == ST_IDLE) && item_valid_i;
  assign empty_o      = !out_valid_q;
  assign sample_out_o = out_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !pop_i;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = ST_MUL;
          step_d  = '0;
        end
      end
      ST_MUL: begin
        if (step_q == STEP_BITS'(2)) begin
          state_d = ST_SUM;
          step_d  = '0;
        end else begin
          step_d = step_q + STEP_BITS'(1);
        end
      end
      ST_SUM: state_d = ST_SAT;
      ST_SAT: begin
        if (gate_q) begin
          count_d = LEN_BITS'(1);
          state_d = ST_OUT;
        end else begin
          count_d = (count_q >= len_eff) ? len_eff : count_q + LEN_BITS'(1);
          state_d = ST_VMUL;
        end
      end
      ST_VMUL: state_d = ST_DLOAD;
      ST_DLOAD: begin
        state_d = ST_DIV;
        step_d  = '0;
      end
      ST_DIV: begin
        if (step_q == STEP_BITS'(QBITS - 1)) begin
          state_d = ST_OUT;
          step_d  = '0;
        end else begin
          step_d = step_q + STEP_BITS'(1);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      count_q     <= LEN_BITS'(1);
      y1_q        <= '0;
      y2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_SAT) begin
        y1_q <= y_sat;
        y2_q <= y1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        x_q    <= item_sample_i;
        gate_q <= item_gate_i;
      end
      ST_MUL: begin
        prod_q <= mul_res;
        if (step_q == '0) begin
          acc_q <= '0;
        end else begin
          acc_q <= acc_q + ACC_BITS'(prod_q);
        end
      end
      ST_SUM: acc_q <= acc_q + ACC_BITS'(prod_q);
      ST_SAT: begin
        y_q    <= y_sat;
        neg_q  <= y_sat[DATA_BITS-1];
        mag_q  <= y_sat[DATA_BITS-1] ? DATA_BITS'(-y_sat) : DATA_BITS'(y_sat);
        diff_q <= len_eff - cnt_clip;
      end
      ST_VMUL: nprod_q <= NPROD_BITS'(mag_q) * NPROD_BITS'(diff_q);
      ST_DLOAD: begin
        // The quotient is below 2**(DATA_BITS-1), so the upper part is already below len.
        rem_q <= nprod_q[QBITS +: LEN_BITS];
        low_q <= nprod_q[QBITS-1:0];
      end
      ST_DIV: begin
        rem_q <= div_ge ? div_sub[LEN_BITS-1:0] : div_shift[LEN_BITS-1:0];
        low_q <= {low_q[QBITS-2:0], div_ge};
      end
      ST_OUT: begin
        if (out_free) begin
          out_q <= res;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/resonant_lowpass_and_decay_vca_top.sv =====
// Path: an accepted request first waits in the input queue; the sequencer then runs its
// multiply, sum and saturate states, and for a decaying request the envelope multiply,
// divider load and serial divide states, before it is written to the result register; the
// serial divider makes that path the longer one. The sequencer runs one request at a time;
// a two-entry input queue and a result register let both sides stall on their own.
// Reset (asynchronous, active low): coefficients and filter history clear, decay length
// and count go to 1 (fully decayed), both queues empty.
module resonant_lowpass_and_decay_vca_top #(
  parameter int DATA_BITS = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [DATA_BITS-1:0]            sample_in_i,
  input  logic                                   gate_i,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [DATA_BITS-1:0]            sample_out_o,
  input  logic                                   cfg_we_i,
  input  logic [rlpv_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [rlpv_pkg::COEF_BITS-1:0]         cfg_data_i
);

  rlpv_pkg::cfg_t cfg_q, cfg_d;

  logic                        item_valid, item_gate, item_take;
  logic signed [DATA_BITS-1:0] item_sample;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rlpv_pkg::REG_GAIN_B1:   cfg_d.gain_b1      = cfg_data_i;
        rlpv_pkg::REG_FB_A1:     cfg_d.fb_a1        = cfg_data_i;
        rlpv_pkg::REG_FB_A2:     cfg_d.fb_a2        = cfg_data_i;
        rlpv_pkg::REG_DECAY_LEN: cfg_d.decay_length = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_b1      <= '0;
      cfg_q.fb_a1        <= '0;
      cfg_q.fb_a2        <= '0;
      cfg_q.decay_length <= rlpv_pkg::LEN_BITS'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rlpv_front #(
    .DATA_BITS(DATA_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .sample_in_i  (sample_in_i),
    .gate_i       (gate_i),
    .item_valid_o (item_valid),
    .item_sample_o(item_sample),
    .item_gate_o  (item_gate),
    .item_take_i  (item_take)
  );

  rlpv_back #(
    .DATA_BITS(DATA_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_sample_i(item_sample),
    .item_gate_i  (item_gate),
    .item_take_o  (item_take),
    .empty_o      (empty),
    .pop_i        (pop),
    .sample_out_o (sample_out_o)
  );

endmodule

// ===== rtl/rlpv_checker.sv =====
// Port-level checker for the resonant lowpass and decay amplifier top level.
// Tracks requests in flight and checks queue flags against it; bound to the top level.
// No package dependencies.
module rlpv_checker #(
  parameter int DATA_BITS = 8
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        push,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic signed [DATA_BITS-1:0] sample_out_o
);

  logic [2:0] inflight_q, inflight_d;
  logic       acc_in, acc_out;

  assign acc_in  = push && !full;
  assign acc_out = pop && !empty;

  always_comb begin
    inflight_d = inflight_q + 3'(acc_in) - 3'(acc_out);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 3'd0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // A waiting result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(sample_out_o))
    else $error("result changed or vanished before pop");

  // No result shows without a request behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> inflight_q != 3'd0)
    else $error("result present with no request in flight");

  // The input queue reports full only with both entries taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> inflight_q >= 3'd2)
    else $error("full with fewer than two requests in flight");

  // Input queue, sequencer and result register hold four requests at most.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd4)
    else $error("more requests in flight than the block can hold");

endmodule

bind resonant_lowpass_and_decay_vca_top rlpv_checker #(
  .DATA_BITS(DATA_BITS)
) u_rlpv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .sample_out_o(sample_out_o)
);
